>>> src/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

    localparam int unsigned TDATA_W = 16;
    localparam logic [7:0]  MSB_MASK = 8'h80;

    typedef enum logic [2:0] {
        ACT_START    = 3'd0,
        ACT_STOP     = 3'd1,
        ACT_WRITE    = 3'd2,
        ACT_READ     = 3'd3,
        ACT_SEND_ACK = 3'd4,
        ACT_READ_ACK = 3'd5,
        ACT_TICK     = 3'd6
    } act_t;

    typedef enum logic [2:0] {
        OP_IDLE     = 3'd0,
        OP_START    = 3'd1,
        OP_STOP     = 3'd2,
        OP_WRITE    = 3'd3,
        OP_READ     = 3'd4,
        OP_SEND_ACK = 3'd5,
        OP_READ_ACK = 3'd6
    } op_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       ack_bit;
        logic       sda_level;
    } req_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        op_t        current_op;
        logic [4:0] step_index;
        logic [7:0] tx_shift;
        logic [7:0] rx_shift;
        logic [7:0] hold_count;
    } state_t;

    typedef struct packed {
        logic       rejected;
        logic       ack_in;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } res_t;

    localparam state_t STATE_RESET = '{
        scl_level:  1'b1,
        sda_drive:  1'b1,
        current_op: OP_IDLE,
        step_index: 5'd0,
        tx_shift:   8'd0,
        rx_shift:   8'd0,
        hold_count: 8'd0
    };

    function automatic logic [4:0] op_length(input op_t op);
        logic [4:0] len;
        unique case (op)
            OP_START:    len = 5'd4;
            OP_STOP:     len = 5'd3;
            OP_WRITE:    len = 5'd24;
            OP_READ:     len = 5'd17;
            OP_SEND_ACK: len = 5'd3;
            OP_READ_ACK: len = 5'd3;
            default:     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> src/i2cm_step.sv
`default_nettype none

module i2cm_step (
    input  var i2cm_pkg::state_t cur,
    input  var i2cm_pkg::req_t   req,
    input  wire logic [7:0]      hold_ticks,
    output i2cm_pkg::state_t     nxt,
    output i2cm_pkg::res_t       res
);
    import i2cm_pkg::*;

    logic [8:0] idx_prod;
    logic [2:0] bit_idx;
    logic [1:0] phase;
    logic [4:0] step_inc;
    logic       check;
    logic       busy;

    // k / 3 as (k * 11) >> 5, exact for the step range
    assign idx_prod = {4'd0, cur.step_index} * 9'd11;
    assign bit_idx  = idx_prod[7:5];
    assign phase    = 2'(cur.step_index - ({2'd0, bit_idx} * 5'd3));
    assign step_inc = cur.step_index + 5'd1;
    assign busy     = (cur.current_op != OP_IDLE);

    always_comb begin
        nxt          = cur;
        check        = 1'b0;
        res.rejected = 1'b0;
        res.done_res = 1'b0;
        res.rx_byte  = 8'd0;
        res.ack_in   = 1'b0;
        unique case (act_t'(req.action))
            ACT_START, ACT_STOP, ACT_WRITE, ACT_READ, ACT_SEND_ACK, ACT_READ_ACK: begin
                if (busy) begin
                    res.rejected = 1'b1;
                end else begin
                    nxt.current_op = op_t'(3'(req.action + 3'd1));
                    nxt.step_index = 5'd0;
                    nxt.hold_count = 8'd0;
                    nxt.rx_shift   = 8'd0;
                    nxt.tx_shift   = (act_t'(req.action) == ACT_SEND_ACK)
                                   ? {7'd0, req.ack_bit} : req.tx_byte;
                end
            end
            ACT_TICK: begin
                if (busy) begin
                    if (cur.hold_count != 8'd0) begin
                        nxt.hold_count = cur.hold_count - 8'd1;
                        check          = (cur.hold_count == 8'd1);
                    end else begin
                        nxt.step_index = step_inc;
                        nxt.hold_count = hold_ticks;
                        check          = (hold_ticks == 8'd0);
                        unique case (cur.current_op)
                            OP_START: begin
                                unique case (cur.step_index)
                                    5'd0:    nxt.sda_drive = 1'b1;
                                    5'd1:    nxt.scl_level = 1'b1;
                                    5'd2:    nxt.sda_drive = 1'b0;
                                    default: nxt.scl_level = 1'b0;
                                endcase
                            end
                            OP_STOP: begin
                                unique case (cur.step_index)
                                    5'd0:    nxt.sda_drive = 1'b0;
                                    5'd1:    nxt.scl_level = 1'b1;
                                    default: nxt.sda_drive = 1'b1;
                                endcase
                            end
                            OP_WRITE: begin
                                unique case (phase)
                                    2'd0:    nxt.sda_drive = |(cur.tx_shift &
                                                               (MSB_MASK >> bit_idx));
                                    2'd1:    nxt.scl_level = 1'b1;
                                    default: nxt.scl_level = 1'b0;
                                endcase
                            end
                            OP_READ: begin
                                if (cur.step_index == 5'd0) begin
                                    nxt.sda_drive = 1'b1;
                                end else if (cur.step_index[0]) begin
                                    nxt.scl_level = 1'b1;
                                end else begin
                                    nxt.rx_shift  = {cur.rx_shift[6:0], req.sda_level};
                                    nxt.scl_level = 1'b0;
                                end
                            end
                            OP_SEND_ACK: begin
                                unique case (cur.step_index)
                                    5'd0:    nxt.sda_drive = cur.tx_shift[0];
                                    5'd1:    nxt.scl_level = 1'b1;
                                    default: nxt.scl_level = 1'b0;
                                endcase
                            end
                            OP_READ_ACK: begin
                                unique case (cur.step_index)
                                    5'd0: nxt.sda_drive = 1'b1;
                                    5'd1: nxt.scl_level = 1'b1;
                                    default: begin
                                        nxt.rx_shift  = {7'd0, req.sda_level};
                                        nxt.scl_level = 1'b0;
                                    end
                                endcase
                            end
                            default: ;
                        endcase
                    end
                    if (check && (nxt.step_index >= op_length(cur.current_op))) begin
                        res.done_res = 1'b1;
                        if (cur.current_op == OP_READ) begin
                            res.rx_byte = nxt.rx_shift;
                        end
                        if (cur.current_op == OP_READ_ACK) begin
                            res.ack_in = nxt.rx_shift[0];
                        end
                        nxt.current_op = OP_IDLE;
                    end
                end
            end
            default: ;
        endcase
        res.scl_out  = nxt.scl_level;
        res.sda_out  = nxt.sda_drive;
        res.busy_res = (nxt.current_op != OP_IDLE);
    end

endmodule

`default_nettype wire

>>> src/i2c_master_byte_engine.sv
// I2C master byte engine. Command requests (start, stop, write byte, read byte,
// send ack, read ack) load an operation while idle; tick requests then perform
// one SCL/SDA pin write each, followed by hold_ticks held ticks, and every
// request returns one result with the pin drive levels (1 = released). A
// request accepted at one edge is registered, then stepped through the
// controller state once the output register is empty or m_tready is high;
// its result and the new state are registered at that edge. The block takes
// one request per cycle whenever m_tready is high; the combinational state
// update is what sets that rate.
// A command while busy is dropped and flagged as rejected. hold_ticks may be
// written over cfg_* only while no request is in flight.
`default_nettype none

module i2c_master_byte_engine (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [2:0] action, [10:3] tx_byte, [11] ack_bit, [12] sda_level
    input  wire logic [i2cm_pkg::TDATA_W-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte,
    // [12] ack_in, [13] rejected
    output logic [i2cm_pkg::TDATA_W-1:0]        m_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [7:0]                     cfg_data
);
    import i2cm_pkg::*;

    logic       in_valid_reg;
    req_t       in_req_reg;
    state_t     state_reg;
    state_t     state_next;
    res_t       res_next;
    logic       out_valid_reg;
    res_t       out_res_reg;
    logic [7:0] hold_ticks_reg;
    logic       advance;
    req_t       s_req;

    assign s_req.action    = s_tdata[2:0];
    assign s_req.tx_byte   = s_tdata[10:3];
    assign s_req.ack_bit   = s_tdata[11];
    assign s_req.sda_level = s_tdata[12];

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'd0, out_res_reg.rejected, out_res_reg.ack_in,
                        out_res_reg.rx_byte, out_res_reg.done_res,
                        out_res_reg.busy_res, out_res_reg.sda_out, out_res_reg.scl_out};

    i2cm_step u_step (
        .cur        (state_reg),
        .req        (in_req_reg),
        .hold_ticks (hold_ticks_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= STATE_RESET;
            hold_ticks_reg <= 8'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                hold_ticks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg <= s_req;
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

>>> src/i2cm_checker.sv
`default_nettype none

module i2cm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> !m_tdata[2])
        else $error("done with busy still set");

    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[13]) |-> (m_tdata[2] && !m_tdata[3]))
        else $error("rejected request while idle or done");

    a_rx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[3]) |-> ((m_tdata[11:4] == 8'd0) && !m_tdata[12]))
        else $error("rx data without done");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import i2cm_pkg::*;

    localparam logic [2:0] ACT_NOP   = 3'd7;
    localparam int         ITEMS     = 1950;
    localparam int         PHASE_LEN = 120;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    i2c_master_byte_engine i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // engine shadow state
    logic       bus_scl, bus_sda, eng_busy;
    op_t        eng_op;
    logic [4:0] eng_step;
    logic [7:0] eng_tx, eng_rx, eng_hold_cnt, eng_hold_cfg;

    req_t cmd_q[$];
    res_t pin_q[$];
    req_t cur_req;
    res_t cur_res;

    int n_err = 0, n_req = 0, n_res = 0, n_done = 0, n_rej = 0, n_cfg = 0;
    int n_gen = 0;
    int hold_now = 0;
    int burst_left = 0, gap_left = 0;
    int stall_mode = 0, stall_left = 0;
    logic [31:0] stall_pat = '1;

    function automatic int writes_for(input op_t op);
        case (op)
            OP_START:                          return 4;
            OP_STOP, OP_SEND_ACK, OP_READ_ACK: return 3;
            OP_WRITE:                          return 24;
            OP_READ:                           return 17;
            default:                           return 0;
        endcase
    endfunction

    task automatic pin_write(input logic [4:0] k, input logic sda_in);
        logic [2:0] bit_i;
        logic [1:0] ph;
        bit_i = 3'(k / 3);
        ph = 2'(k % 3);
        case (eng_op)
            OP_START: begin
                if (k == 0) bus_sda = 1'b1;
                else if (k == 1) bus_scl = 1'b1;
                else if (k == 2) bus_sda = 1'b0;
                else bus_scl = 1'b0;
            end
            OP_STOP: begin
                if (k == 0) bus_sda = 1'b0;
                else if (k == 1) bus_scl = 1'b1;
                else bus_sda = 1'b1;
            end
            OP_WRITE: begin
                if (ph == 0) bus_sda = eng_tx[3'd7 - bit_i];
                else if (ph == 1) bus_scl = 1'b1;
                else bus_scl = 1'b0;
            end
            OP_READ: begin
                if (k == 0) begin
                    bus_sda = 1'b1;
                end else if (k[0]) begin
                    bus_scl = 1'b1;
                end else begin
                    eng_rx = {eng_rx[6:0], sda_in};
                    bus_scl = 1'b0;
                end
            end
            OP_SEND_ACK: begin
                if (k == 0) bus_sda = eng_tx[0];
                else if (k == 1) bus_scl = 1'b1;
                else bus_scl = 1'b0;
            end
            OP_READ_ACK: begin
                if (k == 0) begin
                    bus_sda = 1'b1;
                end else if (k == 1) begin
                    bus_scl = 1'b1;
                end else begin
                    eng_rx = {7'd0, sda_in};
                    bus_scl = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic engine_step(input req_t rq, output res_t rs);
        logic hit;
        hit = 1'b0;
        rs = '0;
        if (rq.action <= ACT_READ_ACK) begin
            if (eng_busy) begin
                rs.rejected = 1'b1;
            end else begin
                eng_op       = op_t'(rq.action + 3'd1);
                eng_busy     = 1'b1;
                eng_step     = '0;
                eng_hold_cnt = '0;
                eng_rx       = '0;
                eng_tx       = (rq.action == ACT_SEND_ACK) ? {7'd0, rq.ack_bit} : rq.tx_byte;
            end
        end else if (rq.action == ACT_TICK && eng_busy) begin
            if (eng_hold_cnt != 0) begin
                eng_hold_cnt = eng_hold_cnt - 8'd1;
                hit = (eng_hold_cnt == 0);
            end else begin
                pin_write(eng_step, rq.sda_level);
                eng_step = eng_step + 5'd1;
                eng_hold_cnt = eng_hold_cfg;
                hit = (eng_hold_cnt == 0);
            end
            if (hit && eng_step >= writes_for(eng_op)) begin
                rs.done_res = 1'b1;
                if (eng_op == OP_READ) rs.rx_byte = eng_rx;
                if (eng_op == OP_READ_ACK) rs.ack_in = eng_rx[0];
                eng_busy = 1'b0;
                eng_op = OP_IDLE;
            end
        end
        rs.scl_out  = bus_scl;
        rs.sda_out  = bus_sda;
        rs.busy_res = eng_busy;
    endtask

    // sender: bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid     <= 1'b0;
            s_tdata      <= '0;
            bus_scl      = 1'b1;
            bus_sda      = 1'b1;
            eng_busy     = 1'b0;
            eng_op       = OP_IDLE;
            eng_step     = '0;
            eng_tx       = '0;
            eng_rx       = '0;
            eng_hold_cnt = '0;
            eng_hold_cfg = '0;
        end else begin
            if (s_tvalid && s_tready) begin
                engine_step(cur_req, cur_res);
                pin_q.push_back(cur_res);
                n_req++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    cur_req = cmd_q.pop_front();
                    s_tdata  <= {3'b000, cur_req.sda_level, cur_req.ack_bit,
                                 cur_req.tx_byte, cur_req.action};
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            n_err++;
        end
    endtask

    // receiver: checks results, stalls on its own pattern
    always @(posedge aclk) begin
        res_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[13:0];
                n_res++;
                if (pin_q.size() == 0) begin
                    $display("%0t: result %h with no request pending", $time, m_tdata);
                    n_err++;
                end else begin
                    want = pin_q.pop_front();
                    check_field("scl_out", want.scl_out, got.scl_out);
                    check_field("sda_out", want.sda_out, got.sda_out);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("rx_byte", want.rx_byte, got.rx_byte);
                    check_field("ack_in", want.ack_in, got.ack_in);
                    check_field("rejected", want.rejected, got.rejected);
                    if (got.done_res) n_done++;
                    if (got.rejected) n_rej++;
                end
            end
            if (stall_left == 0) begin
                stall_left = $urandom_range(20, 200);
                stall_mode = $urandom_range(0, 2);
                stall_pat  = $urandom;
            end else begin
                stall_left--;
            end
            stall_pat = {stall_pat[30:0], stall_pat[31]};
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= stall_pat[0];
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic push_req(input logic [2:0] act, input logic [7:0] tx, input logic ack,
                            input logic sda, input bit counted);
        req_t rq;
        rq.action    = act;
        rq.tx_byte   = tx;
        rq.ack_bit   = ack;
        rq.sda_level = sda;
        cmd_q.push_back(rq);
        if (counted) n_gen++;
    endtask

    task automatic push_tick(input logic sda, input bit counted);
        push_req(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda, counted);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one command with the ticks that complete it, or cut short, with stray requests mixed in
    task automatic add_op(input logic [2:0] act, input bit cut);
        int n_ticks, k, sda_mode;
        logic sda;
        push_req(act, pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
        n_ticks = writes_for(op_t'(act + 3'd1)) * (hold_now + 1);
        if (cut) n_ticks = $urandom_range(1, n_ticks - 1);
        sda_mode = $urandom_range(0, 3);
        for (k = 0; k < n_ticks; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    push_req(3'($urandom_range(0, 5)), pick_byte(), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'b1);
                else
                    push_req(ACT_NOP, pick_byte(), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'b0);
            end
            sda = (sda_mode == 0) ? 1'b0 : (sda_mode == 1) ? 1'b1
                                                           : 1'($urandom_range(0, 1));
            push_tick(sda, 1'b1);
        end
        if (!cut && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_tick(1'($urandom_range(0, 1)), 1'b0);
    endtask

    task automatic drain();
        @(negedge aclk);
        while (cmd_q.size() != 0 || s_tvalid || pin_q.size() != 0) @(negedge aclk);
    endtask

    task automatic write_hold(input int v);
        drain();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= 8'(v);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        eng_hold_cfg = 8'(v);
        hold_now = v;
        n_cfg++;
        cfg_valid <= 1'b0;
    endtask

    // finish an operation left open by the previous phase, at the new hold
    task automatic finish_open_op();
        int left_writes, n;
        if (eng_busy) begin
            left_writes = writes_for(eng_op) - eng_step;
            n = eng_hold_cnt + left_writes * (hold_now + 1);
            repeat (n) push_tick(1'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    initial begin
        int ph, v, start_gen;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, hold at its reset value
        push_req(ACT_TICK, 8'hFF, 1'b1, 1'b1, 1'b0);
        push_req(ACT_NOP, 8'h00, 1'b0, 1'b0, 1'b0);
        push_req(ACT_START, 8'hFF, 1'b1, 1'b1, 1'b0);
        repeat (2) push_tick(1'b1, 1'b0);
        push_req(ACT_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
        repeat (2) push_tick(1'b0, 1'b0);
        push_req(ACT_SEND_ACK, 8'h00, 1'b1, 1'b0, 1'b0);
        repeat (3) push_tick(1'b0, 1'b0);
        push_req(ACT_READ_ACK, 8'hFF, 1'b0, 1'b1, 1'b0);
        repeat (3) push_tick(1'b0, 1'b0);
        push_req(ACT_STOP, 8'hFF, 1'b1, 1'b1, 1'b0);
        repeat (3) push_tick(1'b1, 1'b0);

        ph = 0;
        while (n_gen < ITEMS) begin
            case (ph)
                0:       v = 0;
                1:       v = 1;
                2:       v = 255;
                3:       v = 2;
                default: v = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                          : $urandom_range(0, 3);
            endcase
            write_hold(v);
            finish_open_op();
            start_gen = n_gen;
            if (v == 255) begin
                add_op($urandom_range(0, 2) == 0 ? ACT_STOP : ACT_SEND_ACK, 1'b0);
            end else begin
                if (ph == 0) begin
                    add_op(ACT_WRITE, 1'b0);
                    add_op(ACT_READ, 1'b0);
                end
                while (n_gen - start_gen < PHASE_LEN) add_op(3'($urandom_range(0, 5)), 1'b0);
                if (ph == 3 || (ph > 3 && $urandom_range(0, 2) == 0))
                    add_op(3'($urandom_range(0, 5)), 1'b1);
            end
            drain();
            ph++;
        end

        drain();
        repeat (20) @(posedge aclk);
        $display("tb: %0d requests, %0d results, %0d completed operations, %0d rejected commands",
                 n_req, n_res, n_done, n_rej);
        $display("tb: %0d hold settings written, including 0 and 255", n_cfg);
        if (n_err == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/i2cm_pkg.sv
src/i2cm_step.sv
src/i2c_master_byte_engine.sv
src/i2cm_checker.sv
verif/tb.sv
